>>> hdl/ost_pkg.sv
// ----------------------------------------------------------------------------
// ost_pkg
// Shared types and constants for the ordered symbol table.
// ----------------------------------------------------------------------------
package ost_pkg;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 16;
    localparam int FLAGS_W = 32;
    localparam int IDX_W   = 9;
    localparam int FVAL_W  = 17;
    localparam int POS_W   = 8;
    localparam int OPC_W   = 3;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic [IDX_W-1:0]  NONE_INDEX = '1;
    localparam logic [FVAL_W-1:0] NONE_VALUE = '1;

    typedef enum logic [OPC_W-1:0] {
        OP_INSERT   = 3'd0,
        OP_LOOKUP   = 3'd1,
        OP_READ_IDX = 3'd2,
        OP_DEL_IDX  = 3'd3,
        OP_DEL_KEY  = 3'd4,
        OP_CLEAR    = 3'd5
    } op_t;

    typedef enum logic [0:0] {
        REG_UNKNOWN_TYPE = 1'b0
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
        logic [FLAGS_W-1:0] flags;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> hdl/ost_if.sv
// ----------------------------------------------------------------------------
// ost_if
// Request and response channels of the ordered symbol table.
// ----------------------------------------------------------------------------
interface ost_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [31:0] key_hash;
    logic [15:0] entry_value;
    logic [31:0] entry_type;
    logic [7:0]  position;

    modport source (output valid, opcode, key_hash, entry_value, entry_type, position,
                    input ready);
    modport sink   (input valid, opcode, key_hash, entry_value, entry_type, position,
                    output ready);
endinterface

interface ost_rsp_if;
    logic               valid;
    logic               ready;
    logic               done_ok;
    logic               table_full;
    logic signed [8:0]  found_index;
    logic [31:0]        found_key;
    logic signed [16:0] found_value;
    logic [31:0]        found_type;
    logic [8:0]         entry_count;

    modport source (output valid, done_ok, table_full, found_index, found_key,
                    found_value, found_type, entry_count,
                    input ready);
    modport sink   (input valid, done_ok, table_full, found_index, found_key,
                    found_value, found_type, entry_count,
                    output ready);
endinterface

>>> hdl/ost_ram.sv
// ----------------------------------------------------------------------------
// ost_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ost_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/ordered_symbol_table.sv
// ----------------------------------------------------------------------------
// ordered_symbol_table
// Insertion-ordered symbol table with linear key search and shift-down delete.
// ----------------------------------------------------------------------------
// Clear, a read miss and unused opcodes go straight to the result. A read hit
//   reads the entry by index; key operations scan the entries in order from
//   index 0; a delete that finds its entry shifts every later entry down one place.
// One item at a time: a new request beat is taken only after the result of the
//   last one is loaded into the output register.
// Reset: entry count and unknown type code go to zero; memory is not cleared.
module ordered_symbol_table #(
    parameter int DEPTH = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    ost_req_if.sink                    req,
    ost_rsp_if.source                  rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ost_pkg::ADDR_W-1:0] paddr,
    input  logic [ost_pkg::DATA_W-1:0] pwdata,
    output logic [ost_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    import ost_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int XW   = CW + IDX_W;
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    function automatic logic [IDX_W-1:0] to_idx(input logic [CW-1:0] v);
        logic [XW-1:0] w;
        w = XW'(v);
        return w[IDX_W-1:0];
    endfunction

    state_t              state_reg, state_next;
    logic [OPC_W-1:0]    op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [VAL_W-1:0]    val_reg, val_next;
    logic [FLAGS_W-1:0]  flags_reg, flags_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic                pend_reg, pend_next;
    logic [FLAGS_W-1:0]  unk_reg;

    logic                res_ok_reg, res_ok_next;
    logic                res_full_reg, res_full_next;
    logic [IDX_W-1:0]    res_idx_reg, res_idx_next;
    logic [KEY_W-1:0]    res_key_reg, res_key_next;
    logic [FVAL_W-1:0]   res_val_reg, res_val_next;
    logic [FLAGS_W-1:0]  res_flags_reg, res_flags_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_ok_reg, out_full_reg;
    logic [IDX_W-1:0]    out_idx_reg;
    logic [KEY_W-1:0]    out_key_reg;
    logic [FVAL_W-1:0]   out_val_reg;
    logic [FLAGS_W-1:0]  out_flags_reg;
    logic [IDX_W-1:0]    out_count_reg;
    logic                out_load;

    logic                wr_en, rd_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    entry_t              wr_data, rd_data;

    logic                accept;
    logic                pos_ok;
    logic                hit;
    logic [CW-1:0]       hit_idx;
    logic                cfg_wr;

    ost_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (reg_idx_t'(paddr[2]) == REG_UNKNOWN_TYPE);
    assign prdata = (reg_idx_t'(paddr[2]) == REG_UNKNOWN_TYPE) ? unk_reg : '0;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.done_ok     = out_ok_reg;
    assign rsp.table_full  = out_full_reg;
    assign rsp.found_index = out_idx_reg;
    assign rsp.found_key   = out_key_reg;
    assign rsp.found_value = out_val_reg;
    assign rsp.found_type  = out_flags_reg;
    assign rsp.entry_count = out_count_reg;

    always_comb
    begin
        pos_ok  = (CMPW'(pos_reg) < CMPW'(count_reg)) && (CMPW'(pos_reg) < CMPW'(DEPTH));
        hit     = pend_reg && (rd_data.key == key_reg);
        hit_idx = ptr_reg - CW'(1);
        if (state_reg == ST_IDLE)
        begin
            pos_ok = (CMPW'(req.position) < CMPW'(count_reg))
                     && (CMPW'(req.position) < CMPW'(DEPTH));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            unk_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
            begin
                unk_reg <= pwdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        val_reg       <= val_next;
        flags_reg     <= flags_next;
        pos_reg       <= pos_next;
        ptr_reg       <= ptr_next;
        res_ok_reg    <= res_ok_next;
        res_full_reg  <= res_full_next;
        res_idx_reg   <= res_idx_next;
        res_key_reg   <= res_key_next;
        res_val_reg   <= res_val_next;
        res_flags_reg <= res_flags_next;
        if (out_load)
        begin
            out_ok_reg    <= res_ok_reg;
            out_full_reg  <= res_full_reg;
            out_idx_reg   <= res_idx_reg;
            out_key_reg   <= res_key_reg;
            out_val_reg   <= res_val_reg;
            out_flags_reg <= res_flags_reg;
            out_count_reg <= to_idx(count_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        flags_next     = flags_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        pend_next      = 1'b0;
        res_ok_next    = res_ok_reg;
        res_full_next  = res_full_reg;
        res_idx_next   = res_idx_reg;
        res_key_next   = res_key_reg;
        res_val_next   = res_val_reg;
        res_flags_next = res_flags_reg;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !rsp.ready;
        wr_en          = 1'b0;
        wr_addr        = AW'(count_reg);
        wr_data        = '{key: key_reg, value: val_reg, flags: flags_reg};
        rd_en          = 1'b0;
        rd_addr        = AW'(ptr_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next        = req.opcode;
                    key_next       = req.key_hash;
                    val_next       = req.entry_value;
                    flags_next     = req.entry_type;
                    pos_next       = req.position;
                    ptr_next       = '0;
                    res_ok_next    = 1'b0;
                    res_full_next  = 1'b0;
                    res_idx_next   = NONE_INDEX;
                    res_key_next   = '0;
                    res_val_next   = '0;
                    res_flags_next = '0;
                    state_next     = ST_FINISH;
                    unique case (req.opcode)
                        OP_INSERT, OP_LOOKUP, OP_DEL_KEY:
                        begin
                            state_next = ST_SCAN;
                        end
                        OP_READ_IDX:
                        begin
                            if (pos_ok)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(req.position);
                                state_next = ST_READ;
                            end
                            else
                            begin
                                res_val_next   = NONE_VALUE;
                                res_flags_next = unk_reg;
                            end
                        end
                        OP_DEL_IDX:
                        begin
                            if (pos_ok)
                            begin
                                res_ok_next  = 1'b1;
                                res_idx_next = IDX_W'(req.position);
                                ptr_next     = CW'(CMPW'(req.position) + CMPW'(1));
                                state_next   = ST_SHIFT;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next  = '0;
                            res_ok_next = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (hit)
                begin
                    res_idx_next = to_idx(hit_idx);
                    state_next   = ST_FINISH;
                    if (op_reg == OP_LOOKUP)
                    begin
                        res_ok_next    = 1'b1;
                        res_val_next   = {1'b0, rd_data.value};
                        res_flags_next = rd_data.flags;
                    end
                    else if (op_reg == OP_DEL_KEY)
                    begin
                        res_ok_next = 1'b1;
                        state_next  = ST_SHIFT;
                    end
                end
                else if (ptr_reg < count_reg)
                begin
                    rd_en     = 1'b1;
                    ptr_next  = ptr_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    state_next = ST_FINISH;
                    if (op_reg == OP_INSERT)
                    begin
                        if (CMPW'(count_reg) >= CMPW'(DEPTH))
                        begin
                            res_full_next = 1'b1;
                        end
                        else
                        begin
                            wr_en        = 1'b1;
                            res_ok_next  = 1'b1;
                            res_idx_next = to_idx(count_reg);
                            count_next   = count_reg + CW'(1);
                        end
                    end
                    else if (op_reg == OP_LOOKUP)
                    begin
                        res_val_next   = NONE_VALUE;
                        res_flags_next = unk_reg;
                    end
                end
            end

            ST_READ:
            begin
                res_ok_next    = 1'b1;
                res_idx_next   = IDX_W'(pos_reg);
                res_key_next   = rd_data.key;
                res_val_next   = {1'b0, rd_data.value};
                res_flags_next = rd_data.flags;
                state_next     = ST_FINISH;
            end

            ST_SHIFT:
            begin
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(ptr_reg - CW'(2));
                    wr_data = rd_data;
                end
                if (ptr_reg < count_reg)
                begin
                    rd_en     = 1'b1;
                    ptr_next  = ptr_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMPW'(count_reg) <= CMPW'(DEPTH))
        else $error("entry count above depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == '0 || count_reg == $past(count_reg) + CW'(1)
             || count_reg == $past(count_reg) - CW'(1)))
        else $error("entry count moved by more than one");

    a_full_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.table_full |-> !rsp.done_ok)
        else $error("full table reported with success");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_SCAN || state_reg == ST_SHIFT))
        else $error("entry write outside scan or shift");

endmodule

>>> verif/symbol_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// symbol_table_checker
// Watches the request, reply and register ports of the ordered symbol table.
// Keeps its own copy of the table and of the unknown type code, works out the
// reply to every request beat, and compares each reply beat field by field
// with the oldest reply still due.
// ----------------------------------------------------------------------------
module symbol_table_checker #(
    parameter int DEPTH = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    ost_req_if                         req,
    ost_rsp_if                         rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ost_pkg::ADDR_W-1:0] paddr,
    input  logic [ost_pkg::DATA_W-1:0] pwdata,
    input  logic                       pready,
    output int                         fail_count,
    output int                         pending,
    output int                         checked,
    output int                         full_hits
);

    import ost_pkg::*;

    localparam logic [ADDR_W-1:0] UNKNOWN_TYPE_ADDR = ADDR_W'(4 * int'(REG_UNKNOWN_TYPE));

    typedef struct packed {
        logic               done_ok;
        logic               table_full;
        logic [IDX_W-1:0]   index;
        logic [KEY_W-1:0]   key;
        logic [FVAL_W-1:0]  value;
        logic [FLAGS_W-1:0] flags;
        logic [IDX_W-1:0]   count;
    } reply_t;

    logic [KEY_W-1:0]   keys_held [DEPTH];
    logic [VAL_W-1:0]   values_held [DEPTH];
    logic [FLAGS_W-1:0] flags_held [DEPTH];
    int                 held = 0;
    logic [DATA_W-1:0]  miss_flags = '0;
    reply_t             replies_due [$];

    function automatic void remove_entry(int at);
        for (int i = at; i + 1 < held; i++)
        begin
            keys_held[i]   = keys_held[i + 1];
            values_held[i] = values_held[i + 1];
            flags_held[i]  = flags_held[i + 1];
        end
        held--;
    endfunction

    function automatic reply_t apply_request(logic [OPC_W-1:0] op, logic [KEY_W-1:0] key,
                                             logic [VAL_W-1:0] value,
                                             logic [FLAGS_W-1:0] flags,
                                             logic [POS_W-1:0] pos);
        reply_t r;
        int     hit_at;
        r       = '0;
        r.index = NONE_INDEX;
        hit_at  = -1;
        for (int i = 0; i < held; i++)
        begin
            if (keys_held[i] == key)
            begin
                hit_at = i;
                break;
            end
        end
        case (op)
            OP_INSERT:
            begin
                if (hit_at >= 0)
                    r.index = IDX_W'(hit_at);
                else if (held >= DEPTH)
                    r.table_full = 1'b1;
                else
                begin
                    keys_held[held]   = key;
                    values_held[held] = value;
                    flags_held[held]  = flags;
                    r.index           = IDX_W'(held);
                    r.done_ok         = 1'b1;
                    held++;
                end
            end
            OP_LOOKUP:
            begin
                if (hit_at >= 0)
                begin
                    r.done_ok = 1'b1;
                    r.index   = IDX_W'(hit_at);
                    r.value   = FVAL_W'(values_held[hit_at]);
                    r.flags   = flags_held[hit_at];
                end
                else
                begin
                    r.value = NONE_VALUE;
                    r.flags = miss_flags;
                end
            end
            OP_READ_IDX:
            begin
                if (int'(pos) < held)
                begin
                    r.done_ok = 1'b1;
                    r.index   = IDX_W'(pos);
                    r.key     = keys_held[pos];
                    r.value   = FVAL_W'(values_held[pos]);
                    r.flags   = flags_held[pos];
                end
                else
                begin
                    r.value = NONE_VALUE;
                    r.flags = miss_flags;
                end
            end
            OP_DEL_IDX:
            begin
                if (int'(pos) < held)
                begin
                    remove_entry(int'(pos));
                    r.done_ok = 1'b1;
                    r.index   = IDX_W'(pos);
                end
            end
            OP_DEL_KEY:
            begin
                if (hit_at >= 0)
                begin
                    remove_entry(hit_at);
                    r.done_ok = 1'b1;
                    r.index   = IDX_W'(hit_at);
                end
            end
            OP_CLEAR:
            begin
                held      = 0;
                r.done_ok = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.count = IDX_W'(held);
        return r;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            held       = 0;
            miss_flags = '0;
            replies_due.delete();
            pending    = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("reply beat with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    checked++;
                    compare_field("done_ok", {31'b0, want.done_ok}, {31'b0, rsp.done_ok});
                    compare_field("table_full", {31'b0, want.table_full},
                                  {31'b0, rsp.table_full});
                    compare_field("found_index", {23'b0, want.index}, {23'b0, rsp.found_index});
                    compare_field("found_key", want.key, rsp.found_key);
                    compare_field("found_value", {15'b0, want.value}, {15'b0, rsp.found_value});
                    compare_field("found_type", want.flags, rsp.found_type);
                    compare_field("entry_count", {23'b0, want.count}, {23'b0, rsp.entry_count});
                end
            end
            if (req.valid && req.ready)
            begin
                want = apply_request(req.opcode, req.key_hash, req.entry_value,
                                     req.entry_type, req.position);
                if (want.table_full)
                    full_hits++;
                replies_due.insert(replies_due.size(), want);
            end
            if (psel && penable && pwrite && pready && paddr == UNKNOWN_TYPE_ADDR)
                miss_flags = pwdata;
            pending = replies_due.size();
        end
    end

endmodule

>>> verif/ordered_symbol_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_symbol_table_tb
// Drives the ordered symbol table with a directed opening, a fill to a full
// table and four random phases under different handshake pressure and
// unknown type codes. The checker beside the block predicts and compares;
// this module makes stimulus, guards against hangs and gives the verdict.
// ----------------------------------------------------------------------------
module ordered_symbol_table_tb;
    import ost_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 220;
    localparam logic [ADDR_W-1:0] UNKNOWN_TYPE_ADDR = ADDR_W'(4 * int'(REG_UNKNOWN_TYPE));
    localparam logic [OPC_W-1:0]  OP_SPARE_6 = 3'd6;
    localparam logic [OPC_W-1:0]  OP_SPARE_7 = 3'd7;

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                idle_pct  = 0;
    int                stall_pct = 0;
    int                sent = 0;
    int                idle_cycles = 0;
    int                fail_count;
    int                pending;
    int                checked;
    int                full_hits;

    ost_req_if req_if ();
    ost_rsp_if rsp_if ();

    ordered_symbol_table #(
        .DEPTH(TABLE_DEPTH)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req_if),
        .rsp    (rsp_if),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    symbol_table_checker #(
        .DEPTH(TABLE_DEPTH)
    ) reply_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .fail_count(fail_count),
        .pending   (pending),
        .checked   (checked),
        .full_hits (full_hits)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
        rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send(logic [OPC_W-1:0] op, logic [KEY_W-1:0] key,
                        logic [VAL_W-1:0] value, logic [FLAGS_W-1:0] flags,
                        logic [POS_W-1:0] pos);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid       = 1'b1;
        req_if.opcode      = op;
        req_if.key_hash    = key;
        req_if.entry_value = value;
        req_if.entry_type  = flags;
        req_if.position    = pos;
        do
            @(posedge clk);
        while (!req_if.ready);
        sent++;
        @(negedge clk);
    endtask

    task automatic write_unknown_type(logic [DATA_W-1:0] code);
        req_if.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = UNKNOWN_TYPE_ADDR;
        pwdata  = code;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic fill_table();
        logic [KEY_W-1:0] keys [TABLE_DEPTH];
        send(OP_CLEAR, $urandom, 16'($urandom), $urandom, 8'($urandom));
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            keys[i] = ($urandom & 32'hFFFF_FF00) | KEY_W'(i);
            send(OP_INSERT, keys[i], 16'($urandom), $urandom, 8'($urandom));
        end
        send(OP_INSERT, keys[0] ^ 32'h0000_0100, 16'($urandom), $urandom, 8'($urandom));
        send(OP_INSERT, keys[TABLE_DEPTH-1], 16'($urandom), $urandom, 8'($urandom));
        send(OP_LOOKUP, keys[TABLE_DEPTH-1], 16'($urandom), $urandom, 8'($urandom));
        send(OP_READ_IDX, $urandom, 16'($urandom), $urandom, POS_W'(TABLE_DEPTH - 1));
        send(OP_DEL_KEY, keys[1], 16'($urandom), $urandom, 8'($urandom));
        send(OP_READ_IDX, $urandom, 16'($urandom), $urandom, 8'd1);
        send(OP_READ_IDX, $urandom, 16'($urandom), $urandom, POS_W'(TABLE_DEPTH - 1));
        send(OP_DEL_IDX, $urandom, 16'($urandom), $urandom, POS_W'(TABLE_DEPTH - 2));
        send(OP_DEL_IDX, $urandom, 16'($urandom), $urandom, 8'd0);
        send(OP_INSERT, keys[1], 16'($urandom), $urandom, 8'($urandom));
        send(OP_LOOKUP, keys[1], 16'($urandom), $urandom, 8'($urandom));
    endtask

    task automatic random_items(int count);
        logic [KEY_W-1:0] pool [16];
        logic [KEY_W-1:0] key;
        logic [OPC_W-1:0] op;
        logic [POS_W-1:0] pos;
        int               pick;
        foreach (pool[i])
            pool[i] = $urandom;
        pool[0] = '0;
        pool[1] = '1;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                pool[$urandom_range(0, 15)] = $urandom;
            key  = ($urandom_range(0, 4) == 0) ? $urandom : pool[$urandom_range(0, 15)];
            pos  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 23));
            pick = $urandom_range(0, 99);
            if (pick < 34)
                op = OP_INSERT;
            else if (pick < 54)
                op = OP_LOOKUP;
            else if (pick < 68)
                op = OP_READ_IDX;
            else if (pick < 80)
                op = OP_DEL_IDX;
            else if (pick < 93)
                op = OP_DEL_KEY;
            else if (pick < 96)
                op = OP_CLEAR;
            else if (pick < 98)
                op = OP_SPARE_6;
            else
                op = OP_SPARE_7;
            send(op, key, 16'($urandom), $urandom, pos);
        end
    endtask

    task automatic run_phase(int idle, int stall, logic [DATA_W-1:0] code, int count);
        write_unknown_type(code);
        idle_pct  = idle;
        stall_pct = stall;
        random_items(count);
    endtask

    initial
    begin
        req_if.valid       = 1'b0;
        req_if.opcode      = '0;
        req_if.key_hash    = '0;
        req_if.entry_value = '0;
        req_if.entry_type  = '0;
        req_if.position    = '0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        repeat (11)
            @(negedge clk);
        rst_n = 1'b1;

        send(OP_LOOKUP, 32'h0, 16'h0, 32'h0, 8'd0);
        send(OP_READ_IDX, 32'h0, 16'h0, 32'h0, 8'd0);
        send(OP_READ_IDX, 32'h0, 16'h0, 32'h0, 8'd255);
        send(OP_DEL_IDX, 32'h0, 16'h0, 32'h0, 8'd0);
        send(OP_DEL_KEY, 32'hFFFF_FFFF, 16'h0, 32'h0, 8'd0);
        send(OP_INSERT, 32'h0, 16'h0, 32'h0, 8'd0);
        send(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'd255);
        send(OP_INSERT, 32'h1234_5678, 16'h8001, 32'hA5A5_A5A5, 8'd7);
        send(OP_INSERT, 32'h0, 16'h5555, 32'h5A5A_5A5A, 8'd0);
        send(OP_LOOKUP, 32'hFFFF_FFFF, 16'h0, 32'h0, 8'd0);
        send(OP_LOOKUP, 32'h0, 16'h0, 32'h0, 8'd0);
        send(OP_LOOKUP, 32'h5A5A_5A5A, 16'h0, 32'h0, 8'd0);
        send(OP_READ_IDX, 32'h0, 16'h0, 32'h0, 8'd2);
        send(OP_READ_IDX, 32'h0, 16'h0, 32'h0, 8'd3);
        send(OP_SPARE_6, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'd1);
        send(OP_SPARE_7, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'd255);
        send(OP_DEL_IDX, 32'h0, 16'h0, 32'h0, 8'd0);
        send(OP_READ_IDX, 32'h0, 16'h0, 32'h0, 8'd0);
        send(OP_DEL_KEY, 32'h1234_5678, 16'h0, 32'h0, 8'd0);
        send(OP_DEL_KEY, 32'h1234_5678, 16'h0, 32'h0, 8'd0);
        send(OP_DEL_IDX, 32'h0, 16'h0, 32'h0, 8'd200);
        send(OP_CLEAR, 32'h0, 16'h0, 32'h0, 8'd0);
        send(OP_LOOKUP, 32'hFFFF_FFFF, 16'h0, 32'h0, 8'd0);
        send(OP_CLEAR, 32'h0, 16'h0, 32'h0, 8'd0);

        run_phase(0, 0, 32'hFFFF_FFFF, PHASE_ITEMS);
        run_phase(46, 0, $urandom, PHASE_ITEMS);
        fill_table();
        run_phase(0, 46, 32'h0, PHASE_ITEMS);
        run_phase(38, 38, 32'h8000_0001, PHASE_ITEMS);

        req_if.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (2 * TABLE_DEPTH + 8)
            @(negedge clk);

        $display("Sent %0d requests over four handshake phases and four unknown type codes,",
                 sent);
        $display("including a full table; %0d replies compared, %0d full refusals seen.",
                 checked, full_hits);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
